/* rtl/core/bsw_pkg.sv */
// ----------------------------------------------------------------------------
// bsw_pkg
// Shared types, widths, button codes and register indexes of the stopwatch.
// ----------------------------------------------------------------------------
package bsw_pkg;

    localparam int NUM_DIGITS = 5;
    localparam int DIGIT_W    = 4;
    localparam int ADC_W      = 10;
    localparam int TPT_W      = 8;
    localparam int CODE_W     = 3;
    localparam int NUM_THR    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [ADC_W-1:0]   adc_t;
    typedef logic [TPT_W-1:0]   tpt_t;
    typedef logic [CODE_W-1:0]  code_t;
    typedef adc_t [NUM_THR-1:0] thr_array_t;

    localparam code_t BTN_NONE   = 3'd0;
    localparam code_t BTN_RIGHT  = 3'd1;
    localparam code_t BTN_UP     = 3'd2;
    localparam code_t BTN_DOWN   = 3'd3;
    localparam code_t BTN_LEFT   = 3'd4;
    localparam code_t BTN_SELECT = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_TENTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_UP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_DOWN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_LEFT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_SELECT = 3'd5;

    localparam tpt_t RST_TICKS_PER_TENTH  = 8'd60;
    localparam adc_t RST_THRESHOLD_RIGHT  = 10'h032;
    localparam adc_t RST_THRESHOLD_UP     = 10'h0C3;
    localparam adc_t RST_THRESHOLD_DOWN   = 10'h17C;
    localparam adc_t RST_THRESHOLD_LEFT   = 10'h22B;
    localparam adc_t RST_THRESHOLD_SELECT = 10'h316;

    localparam digit_t DIGIT_TOP_NINE = 4'd9;
    localparam digit_t DIGIT_TOP_FIVE = 4'd5;

    typedef struct packed {
        logic clr_time;
        logic clr_lap;
        logic clr_prev;
        logic lap_shift;
    } cell_ctl_t;

    // second tens rolls at five, every other position at nine
    function automatic digit_t digit_top(input int idx);
        digit_t top;
        top = (idx == 2) ? DIGIT_TOP_FIVE : DIGIT_TOP_NINE;
        return top;
    endfunction

endpackage

/* rtl/core/bsw_digit_cell.sv */
// ----------------------------------------------------------------------------
// bsw_digit_cell
// One BCD position of the running time and both lap registers, with carry.
// ----------------------------------------------------------------------------
module bsw_digit_cell
    import bsw_pkg::*;
#(
    parameter digit_t DigitTop = DIGIT_TOP_NINE
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  cell_ctl_t ctl,
    input  logic      carry_in,
    output logic      carry_out,
    output digit_t    time_digit,
    output digit_t    lap_digit,
    output digit_t    prev_digit
);

    digit_t time_reg, time_next;
    digit_t lap_reg,  lap_next;
    digit_t prev_reg, prev_next;
    logic   at_top;

    assign at_top    = (time_reg == DigitTop);
    assign carry_out = carry_in && at_top;

    always_comb begin
        time_next = time_reg;
        lap_next  = lap_reg;
        prev_next = prev_reg;
        if (ctl.clr_time) begin
            time_next = '0;
        end else if (carry_in) begin
            time_next = at_top ? digit_t'(0) : digit_t'(time_reg + digit_t'(1));
        end
        if (ctl.clr_lap) begin
            lap_next = '0;
        end else if (ctl.lap_shift) begin
            lap_next = time_reg;
        end
        if (ctl.clr_prev) begin
            prev_next = '0;
        end else if (ctl.lap_shift) begin
            prev_next = lap_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg <= '0;
            lap_reg  <= '0;
            prev_reg <= '0;
        end else if (load) begin
            time_reg <= time_next;
            lap_reg  <= lap_next;
            prev_reg <= prev_next;
        end
    end

    assign time_digit = time_reg;
    assign lap_digit  = lap_reg;
    assign prev_digit = prev_reg;

endmodule

/* rtl/core/bsw_button_classifier.sv */
// ----------------------------------------------------------------------------
// bsw_button_classifier
// Map a button ladder sample to a button code by ordered thresholds.
// ----------------------------------------------------------------------------
module bsw_button_classifier
    import bsw_pkg::*;
(
    input  adc_t       adc_sample,
    input  thr_array_t thresholds,
    output code_t      button_code
);

    logic [NUM_THR-1:0] below;

    always_comb begin
        for (int i = 0; i < NUM_THR; i++) begin
            below[i] = (adc_sample < thresholds[i]);
        end
    end

    always_comb begin
        if (below[0]) begin
            button_code = BTN_RIGHT;
        end else if (below[1]) begin
            button_code = BTN_UP;
        end else if (below[2]) begin
            button_code = BTN_DOWN;
        end else if (below[3]) begin
            button_code = BTN_LEFT;
        end else if (below[4]) begin
            button_code = BTN_SELECT;
        end else begin
            button_code = BTN_NONE;
        end
    end

endmodule

/* rtl/core/bcd_stopwatch_with_laps.sv */
// ----------------------------------------------------------------------------
// bcd_stopwatch_with_laps
// BCD stopwatch MM:SS.t with current and previous lap, driven by a stream of
// timer ticks and button ladder samples.
//
// Input channel s_*: one transaction is a timer tick (s_tuser = 0) or a
// button sample (s_tuser = 1, ten-bit reading in s_tdata). Each input
// transaction yields exactly one result transaction on m_*, carrying the
// time, both laps, the run flag and the decoded button after the update.
// The result is valid in the cycle after acceptance.
// Throughput is one transaction per cycle while results are taken; the state
// registers double as the output register and a ripple carry through five
// digit cells advances the time in the same cycle.
// When m_tready is low with a result pending, s_tready drops and the state
// and result hold until the result is taken.
// Reset clears the time and laps to 00:00.0, pauses the watch and loads the
// default divider and thresholds. The configuration channel is always ready;
// write it only while no transaction is in flight.
// ----------------------------------------------------------------------------
module bcd_stopwatch_with_laps
    import bsw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [9:0] adc_sample, [15:10] zero
    input  logic [0:0]            s_tuser,   // [0] action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,   // [19:0] time_bcd, [39:20] lap_bcd,
                                             // [59:40] previous_lap_bcd,
                                             // [60] running, [63:61] button_code
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    tpt_t       tpt_reg;
    thr_array_t thr_reg;
    tpt_t       tick_reg, tick_next;
    logic       paused_reg, paused_next;
    logic       held_reg, held_next;
    code_t      code_reg;
    logic       m_tvalid_reg;

    logic       s_accept;
    logic       is_button;
    adc_t       adc;
    code_t      sample_code;
    logic       tick_run;
    logic       tick_hit;
    logic       act;
    cell_ctl_t  ctl;

    logic   [NUM_DIGITS:0]   carry;
    digit_t [NUM_DIGITS-1:0] time_d;
    digit_t [NUM_DIGITS-1:0] lap_d;
    digit_t [NUM_DIGITS-1:0] prev_d;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign is_button = s_tuser[0];
    assign adc       = s_tdata[ADC_W-1:0];
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpt_reg    <= RST_TICKS_PER_TENTH;
            thr_reg[0] <= RST_THRESHOLD_RIGHT;
            thr_reg[1] <= RST_THRESHOLD_UP;
            thr_reg[2] <= RST_THRESHOLD_DOWN;
            thr_reg[3] <= RST_THRESHOLD_LEFT;
            thr_reg[4] <= RST_THRESHOLD_SELECT;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TICKS_PER_TENTH:  tpt_reg    <= cfg_data[TPT_W-1:0];
                REG_THRESHOLD_RIGHT:  thr_reg[0] <= cfg_data[ADC_W-1:0];
                REG_THRESHOLD_UP:     thr_reg[1] <= cfg_data[ADC_W-1:0];
                REG_THRESHOLD_DOWN:   thr_reg[2] <= cfg_data[ADC_W-1:0];
                REG_THRESHOLD_LEFT:   thr_reg[3] <= cfg_data[ADC_W-1:0];
                REG_THRESHOLD_SELECT: thr_reg[4] <= cfg_data[ADC_W-1:0];
                default: ;
            endcase
        end
    end

    bsw_button_classifier u_classifier (
        .adc_sample  (adc),
        .thresholds  (thr_reg),
        .button_code (sample_code)
    );

    // a divider of zero fires on every tick, same as one
    assign tick_run = s_accept && !is_button && !paused_reg;
    assign tick_hit = ({1'b0, tick_reg} + {{TPT_W{1'b0}}, 1'b1}) >= {1'b0, tpt_reg};
    assign carry[0] = tick_run && tick_hit;

    assign act = s_accept && is_button && (sample_code != BTN_NONE) && !held_reg;

    always_comb begin
        ctl.clr_time  = act && (sample_code == BTN_LEFT);
        ctl.clr_lap   = act && ((sample_code == BTN_LEFT) || (sample_code == BTN_DOWN));
        ctl.clr_prev  = act && (sample_code == BTN_DOWN);
        ctl.lap_shift = act && (sample_code == BTN_UP);
    end

    always_comb begin
        tick_next   = tick_reg;
        paused_next = paused_reg;
        held_next   = held_reg;
        if (tick_run) begin
            tick_next = tick_hit ? tpt_t'(0) : tpt_t'(tick_reg + tpt_t'(1));
        end
        if (s_accept && is_button) begin
            held_next = (sample_code != BTN_NONE);
        end
        if (act) begin
            case (sample_code)
                BTN_LEFT:   paused_next = 1'b1;
                BTN_SELECT: paused_next = !paused_reg;
                default:    paused_next = paused_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg     <= '0;
            paused_reg   <= 1'b1;
            held_reg     <= 1'b0;
            code_reg     <= BTN_NONE;
            m_tvalid_reg <= 1'b0;
        end else begin
            tick_reg   <= tick_next;
            paused_reg <= paused_next;
            held_reg   <= held_next;
            if (s_accept) begin
                code_reg     <= is_button ? sample_code : BTN_NONE;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
        bsw_digit_cell #(
            .DigitTop (digit_top(g))
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .load       (s_accept),
            .ctl        (ctl),
            .carry_in   (carry[g]),
            .carry_out  (carry[g+1]),
            .time_digit (time_d[g]),
            .lap_digit  (lap_d[g]),
            .prev_digit (prev_d[g])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {code_reg, !paused_reg, prev_d, lap_d, time_d};

    // top carry out wraps 99:59.9 to zero and is dropped
    logic unused_carry;
    assign unused_carry = carry[NUM_DIGITS];

endmodule

/* tb/sv/stopwatch_tb_pkg.sv */
// ----------------------------------------------------------------------------
// stopwatch_tb_pkg
// Result layout and scoreboard for the BCD stopwatch bench. The scoreboard
// keeps its own copy of the watch state and registers, predicts one reading
// per accepted transaction and compares readings in order.
// ----------------------------------------------------------------------------
package stopwatch_tb_pkg;
    import bsw_pkg::*;

    localparam int BCD_W        = NUM_DIGITS * DIGIT_W;
    localparam int SEC_TENS_POS = 2;

    localparam code_t BTN_BY_THR [NUM_THR] = '{BTN_RIGHT, BTN_UP, BTN_DOWN,
                                               BTN_LEFT, BTN_SELECT};

    typedef logic [BCD_W-1:0] bcd_t;

    typedef struct packed {
        code_t button;
        logic  running;
        bcd_t  prev_lap;
        bcd_t  lap;
        bcd_t  stamp;
    } watch_result_t;

    class stopwatch_scoreboard;
        tpt_t          divider;
        adc_t          thr [NUM_THR];
        bcd_t          clock_digits;
        bcd_t          lap_digits;
        bcd_t          prev_digits;
        tpt_t          tick_count;
        bit            paused;
        bit            press_held;
        watch_result_t expected_readings [$];
        int            errors;

        function new();
            divider      = RST_TICKS_PER_TENTH;
            thr[0]       = RST_THRESHOLD_RIGHT;
            thr[1]       = RST_THRESHOLD_UP;
            thr[2]       = RST_THRESHOLD_DOWN;
            thr[3]       = RST_THRESHOLD_LEFT;
            thr[4]       = RST_THRESHOLD_SELECT;
            clock_digits = '0;
            lap_digits   = '0;
            prev_digits  = '0;
            tick_count   = '0;
            paused       = 1'b1;
            press_held   = 1'b0;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TICKS_PER_TENTH:  divider = data[TPT_W-1:0];
                REG_THRESHOLD_RIGHT:  thr[0] = data;
                REG_THRESHOLD_UP:     thr[1] = data;
                REG_THRESHOLD_DOWN:   thr[2] = data;
                REG_THRESHOLD_LEFT:   thr[3] = data;
                REG_THRESHOLD_SELECT: thr[4] = data;
                default: ;
            endcase
        endfunction

        function int outstanding();
            return expected_readings.size();
        endfunction

        function void note_sample(logic act, adc_t adc);
            code_t         code;
            int            limit;
            int            i;
            logic          carry;
            digit_t        d;
            digit_t        top;
            watch_result_t want;
            code = BTN_NONE;
            if (!act) begin
                if (!paused) begin
                    limit = (divider == 0) ? 1 : int'(divider);
                    if (int'(tick_count) + 1 >= limit) begin
                        tick_count = '0;
                        carry = 1'b1;
                        for (i = 0; i < NUM_DIGITS; i++) begin
                            if (carry) begin
                                d   = clock_digits[i*DIGIT_W +: DIGIT_W];
                                top = (i == SEC_TENS_POS) ? DIGIT_TOP_FIVE : DIGIT_TOP_NINE;
                                if (d == top) begin
                                    clock_digits[i*DIGIT_W +: DIGIT_W] = '0;
                                end else begin
                                    clock_digits[i*DIGIT_W +: DIGIT_W] = d + 1'b1;
                                    carry = 1'b0;
                                end
                            end
                        end
                    end else begin
                        tick_count = tick_count + 1'b1;
                    end
                end
            end else begin
                // first threshold that the sample is below wins
                for (i = NUM_THR - 1; i >= 0; i--) begin
                    if (adc < thr[i]) code = BTN_BY_THR[i];
                end
                if (code == BTN_NONE) begin
                    press_held = 1'b0;
                end else if (!press_held) begin
                    press_held = 1'b1;
                    case (code)
                        BTN_UP: begin
                            prev_digits = lap_digits;
                            lap_digits  = clock_digits;
                        end
                        BTN_DOWN: begin
                            prev_digits = '0;
                            lap_digits  = '0;
                        end
                        BTN_LEFT: begin
                            paused       = 1'b1;
                            clock_digits = '0;
                            lap_digits   = '0;
                        end
                        BTN_SELECT: paused = !paused;
                        default: ;
                    endcase
                end
            end
            want.stamp    = clock_digits;
            want.lap      = lap_digits;
            want.prev_lap = prev_digits;
            want.running  = !paused;
            want.button   = code;
            expected_readings.push_back(want);
        endfunction

        function void check_reading(watch_result_t got);
            watch_result_t want;
            if (expected_readings.size() == 0) begin
                $error("result with no transaction pending: %h", got);
                errors++;
                return;
            end
            want = expected_readings.pop_front();
            if (got.stamp !== want.stamp) begin
                $error("time_bcd: expected %h, actual %h", want.stamp, got.stamp);
                errors++;
            end
            if (got.lap !== want.lap) begin
                $error("lap_bcd: expected %h, actual %h", want.lap, got.lap);
                errors++;
            end
            if (got.prev_lap !== want.prev_lap) begin
                $error("previous_lap_bcd: expected %h, actual %h", want.prev_lap, got.prev_lap);
                errors++;
            end
            if (got.running !== want.running) begin
                $error("running: expected %b, actual %b", want.running, got.running);
                errors++;
            end
            if (got.button !== want.button) begin
                $error("button_code: expected %0d, actual %0d", want.button, got.button);
                errors++;
            end
        endfunction
    endclass

endpackage

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the stopwatch with ticks and button samples under several divider
// and threshold settings, including a fast run with a divider of zero, with
// random gaps and stalls on both streams, and checks every reading.
// ----------------------------------------------------------------------------
module testbench;
    import bsw_pkg::*;
    import stopwatch_tb_pkg::*;

    localparam int NUM_PHASES   = 9;
    localparam int PHASE_ITEMS  = 40;
    localparam int WRAP_TICKS   = 60;
    localparam int LONG_HOLD    = 300;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [63:0]           m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    stopwatch_scoreboard sb;
    bit fast_run      = 1'b0;
    bit sink_free     = 1'b0;
    bit long_hold_req = 1'b0;
    int burst_left    = 0;

    bcd_stopwatch_with_laps i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_reading(watch_result_t'(m_tdata));
            if (s_tvalid && s_tready) sb.note_sample(s_tuser[0], s_tdata[ADC_W-1:0]);
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
        end
    end

    task automatic send_item(input logic act, input adc_t adc);
        int gap;
        int r;
        gap = 0;
        if (!fast_run) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) burst_left = $urandom_range(20, 60);
                else if (r < 45) gap = 0;
                else if (r < 85) gap = $urandom_range(1, 3);
                else if (r < 97) gap = $urandom_range(4, 12);
                else gap = $urandom_range(20, 60);
            end
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {6'b0, adc};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic write_setting(input tpt_t div, input adc_t t_right, input adc_t t_up,
                                 input adc_t t_down, input adc_t t_left, input adc_t t_select);
        write_reg(REG_TICKS_PER_TENTH, {2'b0, div});
        write_reg(REG_THRESHOLD_RIGHT, t_right);
        write_reg(REG_THRESHOLD_UP, t_up);
        write_reg(REG_THRESHOLD_DOWN, t_down);
        write_reg(REG_THRESHOLD_LEFT, t_left);
        write_reg(REG_THRESHOLD_SELECT, t_select);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // drop valid, then wait out every pending reading
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    initial begin
        int hold_left;
        int free_left;
        int r;
        hold_left = 0;
        free_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (sink_free || free_left > 0) begin
                if (free_left > 0) free_left--;
                m_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 4) free_left = $urandom_range(20, 80);
                else if (r < 20) hold_left = $urandom_range(1, 3);
                else if (r < 23) hold_left = $urandom_range(8, 40);
                m_tready <= (hold_left == 0);
            end
        end
    end

    initial begin
        int   ph;
        int   n;
        int   r;
        int   k;
        int   lo;
        int   hi;
        logic act;
        adc_t adc;
        sb = new();
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: press handling, held presses, threshold edges
        send_item(1'b0, 10'd0);
        send_item(1'b0, 10'h3FF);
        send_item(1'b1, 10'd0);
        send_item(1'b1, 10'd1023);
        send_item(1'b1, 10'd600);
        send_item(1'b1, 10'd700);
        send_item(1'b1, 10'd790);
        send_item(1'b0, 10'h3FF);
        send_item(1'b0, 10'h2AA);
        send_item(1'b0, 10'h155);
        send_item(1'b1, 10'd100);
        send_item(1'b1, 10'd1023);
        send_item(1'b1, 10'd200);
        send_item(1'b1, 10'd1023);
        send_item(1'b1, 10'd554);
        send_item(1'b1, 10'd555);
        send_item(1'b1, 10'd1023);
        send_item(1'b1, 10'd789);
        send_item(1'b1, 10'd1023);
        send_item(1'b1, 10'd49);
        send_item(1'b1, 10'd50);
        send_item(1'b1, 10'd1023);
        send_item(1'b0, 10'd0);
        drain();

        // divider of zero, advance a tenth on every tick back to back
        fast_run  = 1'b1;
        sink_free = 1'b1;
        write_setting(8'd0, RST_THRESHOLD_RIGHT, RST_THRESHOLD_UP, RST_THRESHOLD_DOWN,
                      RST_THRESHOLD_LEFT, RST_THRESHOLD_SELECT);
        send_item(1'b1, 10'd1023);
        send_item(1'b1, 10'd400);
        send_item(1'b1, 10'd1023);
        send_item(1'b1, 10'd600);
        send_item(1'b1, 10'd1023);
        for (n = 0; n < WRAP_TICKS; n++) send_item(1'b0, adc_t'($urandom));
        drain();
        fast_run  = 1'b0;
        sink_free = 1'b0;

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: write_setting(8'd1, 10'd50, 10'd195, 10'd380, 10'd555, 10'd790);
                1: write_setting(8'd255, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1023);
                2: write_setting(8'd3, 10'd100, 10'd300, 10'd500, 10'd700, 10'd900);
                3: write_setting(8'd0, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
                4: write_setting(tpt_t'($urandom_range(0, 255)),
                                 adc_t'($urandom_range(0, 1023)), adc_t'($urandom_range(0, 1023)),
                                 adc_t'($urandom_range(0, 1023)), adc_t'($urandom_range(0, 1023)),
                                 adc_t'($urandom_range(0, 1023)));
                5: write_setting(tpt_t'($urandom_range(1, 4)),
                                 adc_t'($urandom_range(0, 1023)), adc_t'($urandom_range(0, 1023)),
                                 adc_t'($urandom_range(0, 1023)), adc_t'($urandom_range(0, 1023)),
                                 adc_t'($urandom_range(0, 1023)));
                6: write_setting(8'd1, RST_THRESHOLD_RIGHT, RST_THRESHOLD_UP,
                                 RST_THRESHOLD_DOWN, RST_THRESHOLD_LEFT, RST_THRESHOLD_SELECT);
                7: write_setting(8'd200, RST_THRESHOLD_RIGHT, RST_THRESHOLD_UP,
                                 RST_THRESHOLD_DOWN, RST_THRESHOLD_LEFT, RST_THRESHOLD_SELECT);
                default: write_setting(8'd5, RST_THRESHOLD_RIGHT, RST_THRESHOLD_UP,
                                       RST_THRESHOLD_DOWN, RST_THRESHOLD_LEFT,
                                       RST_THRESHOLD_SELECT);
            endcase
            if (ph == 2) long_hold_req = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                r   = $urandom_range(0, 99);
                act = 1'b1;
                adc = adc_t'($urandom);
                if (r < 45) begin
                    act = 1'b0;
                end else if (r < 75) begin
                    // press inside one button band
                    k  = $urandom_range(0, NUM_THR - 1);
                    lo = (k == 0) ? 0 : int'(sb.thr[k-1]);
                    hi = int'(sb.thr[k]);
                    if (hi > lo) adc = adc_t'($urandom_range(lo, hi - 1));
                end else if (r < 90) begin
                    adc = adc_t'($urandom_range(int'(sb.thr[NUM_THR-1]), 1023));
                end
                send_item(act, adc);
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
rtl/core/bsw_pkg.sv
rtl/core/bsw_digit_cell.sv
rtl/core/bsw_button_classifier.sv
rtl/core/bcd_stopwatch_with_laps.sv
tb/sv/stopwatch_tb_pkg.sv
tb/sv/testbench.sv
